>>> design/sorted_byte_insertion_buffer_unit_macros.svh
// Assertion macros shared by the sorted byte insertion buffer RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SORTED_BYTE_INSERTION_BUFFER_UNIT_MACROS_SVH
`define SORTED_BYTE_INSERTION_BUFFER_UNIT_MACROS_SVH

// The property must hold at every sampled edge.
`define SBIB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sbib_pkg.sv
// Shared types and constants for the sorted byte insertion buffer.
// No dependencies; imported by the controller, datapath and top level.
package sbib_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_EMIT   = 2'd2
  } sbib_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_FIN,
    ST_EMIT,
    ST_EMPTY
  } sbib_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic append;      // write the input byte at the fill position
    logic ovf_set;     // drop the byte, set the sticky overflow flag
    logic start_scan;  // capture the byte, read slot 0
    logic ins_step;    // compare and shift one slot of the insert pass
    logic ins_final;   // write the carried byte at the end
    logic start_emit;  // read slot 0 for an emit run
    logic emit_load;   // move one stored byte into the output register
    logic empty_load;  // load the single empty-buffer word
  } sbib_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic is_last;     // slot under the pointer is the last stored one
    logic can_load;    // output register is free this cycle
  } sbib_sts_t;

endpackage

>>> design/sorted_byte_insertion_buffer_unit.sv
// Top level of the sorted byte insertion buffer: stream ports, controller and datapath.
// Depends on sbib_pkg, sbib_ctrl and sbib_dpath.
//
// Keeps up to 64 bytes in ascending signed order in a single-port-write,
// single-port-read byte store with registered read data. An append word
// writes its byte at the end. An insert word walks the store once from
// slot 0: each cycle it compares one slot (signed), and from the first
// strictly greater byte onwards rewrites the slot with the carried byte,
// so the tail shifts up by one; a final step writes the carried byte at
// the end. An insert into an empty store is written as an append. An emit
// word reads slot 0 and then streams one stored byte per cycle into an
// output register, tlast on the final byte, pausing while the output is
// stalled; the store and the overflow flag clear with the last byte. An
// emit into an empty store gives one word with the empty flag set. A byte
// that finds the store full is dropped and sets the sticky overflow flag,
// reported on every word of the next emit run. As the memory read is
// registered, each insert and emit first reads slot 0 before its first
// compare or output load. Operation code three is taken and ignored. The
// input side accepts only while the controller idles.
module sorted_byte_insertion_buffer_unit
  import sbib_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser_i,   // [1:0] operation
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic [1:0] m_axis_tuser_o    // [0] empty_res, [1] overflowed
);

  sbib_cmd_t cmd;
  sbib_sts_t sts;

  // Sequence appends, insert passes and emit runs
  sbib_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the store, fill count, overflow flag and output word
  sbib_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_empty_o (m_axis_tuser_o[0]),
    .out_ovf_o   (m_axis_tuser_o[1])
  );

endmodule

>>> design/sbib_ctrl.sv
// Controller state machine for the sorted byte insertion buffer.
// Depends on sbib_pkg; drives the datapath by command struct only.
module sbib_ctrl
  import sbib_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [1:0] in_op_i,
  output logic      in_ready_o,
  input  sbib_sts_t sts_i,
  output sbib_cmd_t cmd_o
);

  sbib_state_e state_q, state_d;
  sbib_op_e    op;

  assign op = sbib_op_e'(in_op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op)
            OP_APPEND: begin
              if (sts_i.full) cmd_o.ovf_set = 1'b1;
              else            cmd_o.append  = 1'b1;
            end
            OP_INSERT: begin
              if (sts_i.full) begin
                cmd_o.ovf_set = 1'b1;
              end else if (sts_i.empty) begin
                cmd_o.append = 1'b1;
              end else begin
                cmd_o.start_scan = 1'b1;
                state_d          = ST_INS;
              end
            end
            OP_EMIT: begin
              if (sts_i.empty) begin
                state_d = ST_EMPTY;
              end else begin
                cmd_o.start_emit = 1'b1;
                state_d          = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS: begin
        cmd_o.ins_step = 1'b1;
        if (sts_i.is_last) state_d = ST_INS_FIN;
      end
      ST_INS_FIN: begin
        cmd_o.ins_final = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.can_load) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.is_last) state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts_i.can_load) begin
          cmd_o.empty_load = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> design/sbib_dpath.sv
// Datapath of the sorted byte insertion buffer: byte store, pointers, output register.
// Depends on sbib_pkg and the assertion macros header.
`include "sorted_byte_insertion_buffer_unit_macros.svh"
module sbib_dpath
  import sbib_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  sbib_cmd_t  cmd_i,
  output sbib_sts_t  sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_empty_o,
  output logic       out_ovf_o
);

  logic [7:0]        mem [CAPACITY];
  logic [7:0]        rd_data_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  idx_q, idx_d, idx_plus;
  logic              ovf_q, ovf_d;
  logic [7:0]        byte_q, carry_q;
  logic              found_q;
  logic              lt;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q, out_empty_q, out_ovf_q;
  logic              load;

  assign idx_plus = idx_q + 1'b1;
  assign lt       = $signed(byte_q) < $signed(rd_data_q);
  assign load     = cmd_i.emit_load | cmd_i.empty_load;

  assign sts_o.full     = (fill_q == CNT_W'(CAPACITY));
  assign sts_o.empty    = (fill_q == '0);
  assign sts_o.is_last  = (idx_q == fill_q - 1'b1);
  assign sts_o.can_load = !out_valid_q || out_ready_i;

  // Memory port steering
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = fill_q[ADDR_W-1:0];
    wdata = data_byte_i;
    raddr = '0;
    if (cmd_i.append) we = 1'b1;
    if (cmd_i.ins_step) begin
      we    = found_q | lt;
      waddr = idx_q[ADDR_W-1:0];
      wdata = carry_q;
      re    = 1'b1;
      raddr = idx_plus[ADDR_W-1:0];
    end
    if (cmd_i.ins_final) begin
      we    = 1'b1;
      wdata = carry_q;
    end
    if (cmd_i.start_scan || cmd_i.start_emit) re = 1'b1;
    if (cmd_i.emit_load) begin
      re    = 1'b1;
      raddr = idx_plus[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data_q <= mem[raddr];
  end

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    idx_d  = idx_q;
    if (cmd_i.append || cmd_i.ins_final) fill_d = fill_q + 1'b1;
    if (cmd_i.ovf_set) ovf_d = 1'b1;
    if (cmd_i.start_scan || cmd_i.start_emit) idx_d = '0;
    if (cmd_i.ins_step || cmd_i.emit_load) idx_d = idx_plus;
    if ((cmd_i.emit_load && sts_o.is_last) || cmd_i.empty_load) begin
      fill_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      idx_q  <= idx_d;
      if (cmd_i.start_scan) found_q <= 1'b0;
      else if (cmd_i.ins_step && lt) found_q <= 1'b1;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Insert pass: the carried byte ripples one slot up from the insert point
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      byte_q  <= data_byte_i;
      carry_q <= data_byte_i;
    end else if (cmd_i.ins_step && (found_q || lt)) begin
      carry_q <= rd_data_q;
    end
    if (load) begin
      out_byte_q  <= cmd_i.empty_load ? 8'h00 : rd_data_q;
      out_last_q  <= cmd_i.empty_load | sts_o.is_last;
      out_empty_q <= cmd_i.empty_load;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;
  assign out_ovf_o   = out_ovf_q;

  `SBIB_ASSERT_ALWAYS(a_fill_range, fill_q <= CNT_W'(CAPACITY), "fill count beyond capacity")
  `SBIB_ASSERT_ALWAYS(a_step_in_range, !cmd_i.ins_step || (idx_q < fill_q), "insert pass past fill")
  `SBIB_ASSERT_ALWAYS(a_no_overwrite, !load || !out_valid_q || out_ready_i, "output word overwritten")
  `SBIB_ASSERT_NEXT(a_emit_clears, cmd_i.emit_load && sts_o.is_last, fill_q == '0 && !ovf_q, "emit did not clear")

endmodule
